// File: rtl/irn_pkg.sv
// Package with the shared types, constants and numeral table of the Roman numeral converter.
package irn_pkg;

  localparam int VALUE_W     = 12;
  localparam int CHAR_W      = 8;
  localparam int STEP_COUNT  = 13;
  localparam int STEP_IDX_W  = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int OUT_DEPTH   = 2;

  localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;
  localparam logic [CHAR_W-1:0]  NO_CHAR   = 8'd0;

  // One checked item (value and range flag) waiting between the front and the back.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               range_error;
  } irn_item_t;

  // One result beat.
  typedef struct packed {
    logic [CHAR_W-1:0] symbol_char;
    logic              last;
    logic              range_error;
  } irn_result_t;

  // Value of each table entry, largest first.
  function automatic logic [VALUE_W-1:0] step_value(input logic [STEP_IDX_W-1:0] idx);
    logic [VALUE_W-1:0] v;
    case (idx)
      4'd0:    v = 12'd1000;
      4'd1:    v = 12'd900;
      4'd2:    v = 12'd500;
      4'd3:    v = 12'd400;
      4'd4:    v = 12'd100;
      4'd5:    v = 12'd90;
      4'd6:    v = 12'd50;
      4'd7:    v = 12'd40;
      4'd8:    v = 12'd10;
      4'd9:    v = 12'd9;
      4'd10:   v = 12'd5;
      4'd11:   v = 12'd4;
      4'd12:   v = 12'd1;
      default: v = 12'd1;
    endcase
    return v;
  endfunction

  // First letter of each table entry.
  function automatic logic [CHAR_W-1:0] step_first(input logic [STEP_IDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      4'd0:    c = "M";
      4'd1:    c = "C";
      4'd2:    c = "D";
      4'd3:    c = "C";
      4'd4:    c = "C";
      4'd5:    c = "X";
      4'd6:    c = "L";
      4'd7:    c = "X";
      4'd8:    c = "X";
      4'd9:    c = "I";
      4'd10:   c = "V";
      4'd11:   c = "I";
      4'd12:   c = "I";
      default: c = "I";
    endcase
    return c;
  endfunction

  // Second letter of the subtractive entries, NO_CHAR for the single-letter ones.
  function automatic logic [CHAR_W-1:0] step_second(input logic [STEP_IDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      4'd1:    c = "M";
      4'd3:    c = "D";
      4'd5:    c = "C";
      4'd7:    c = "L";
      4'd9:    c = "X";
      4'd11:   c = "V";
      default: c = NO_CHAR;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/irn_fifo.sv
// Small register-based queue used between the converter's stages and at its output.
module irn_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/irn_front.sv
// Front end: accepts input values, flags those out of range and queues them for the back end.
module irn_front #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  input  logic [irn_pkg::VALUE_W-1:0] in_value,
  output logic                       in_full,
  input  logic                       q_pop,
  output irn_pkg::irn_item_t         q_item,
  output logic                       q_empty
);

  import irn_pkg::*;

  irn_item_t item;

  // Zero and values above the largest numeral are reported as errors.
  always_comb begin
    item.value       = in_value;
    item.range_error = (in_value == '0) || (in_value > MAX_VALUE);
  end

  irn_fifo #(
    .W     ($bits(irn_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data (item),
    .full      (in_full),
    .pop       (q_pop),
    .pop_data  (q_item),
    .empty     (q_empty)
  );

endmodule

// File: rtl/irn_back.sv
// Back end: walks the numeral table for one queued value and emits one letter per beat.
module irn_back #(
  parameter int OUT_DEPTH = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  irn_pkg::irn_item_t          q_item,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  logic                        out_pop,
  output logic                        out_empty,
  output logic [irn_pkg::CHAR_W-1:0]  out_symbol_char,
  output logic                        out_last,
  output logic                        out_range_error
);

  import irn_pkg::*;

  logic                    busy_r, busy_nxt;
  logic                    err_r, err_nxt;
  logic                    second_r, second_nxt;
  logic [CHAR_W-1:0]       second_char_r, second_char_nxt;
  logic [VALUE_W-1:0]      rem_r, rem_nxt;
  logic [STEP_IDX_W-1:0]   sel;
  logic [VALUE_W-1:0]      rem_sub;
  logic [CHAR_W-1:0]       sel_second;
  logic                    res_push;
  logic                    res_full;
  irn_result_t             res;
  irn_result_t             head;

  // Greedy pick: the largest table entry that still fits into the remainder.
  always_comb begin
    sel = STEP_IDX_W'(STEP_COUNT - 1);
    for (int i = STEP_COUNT - 1; i >= 0; i--) begin
      if (rem_r >= step_value(STEP_IDX_W'(i))) begin
        sel = STEP_IDX_W'(i);
      end
    end
  end

  assign rem_sub    = rem_r - step_value(sel);
  assign sel_second = step_second(sel);

  // A new value is taken only while no conversion is running.
  assign q_pop = !busy_r && !q_empty;

  // Walk control and result beat generation.
  always_comb begin
    busy_nxt        = busy_r;
    err_nxt         = err_r;
    second_nxt      = second_r;
    second_char_nxt = second_char_r;
    rem_nxt         = rem_r;
    res_push        = 1'b0;
    res.symbol_char = NO_CHAR;
    res.last        = 1'b1;
    res.range_error = 1'b0;
    if (!busy_r) begin
      if (!q_empty) begin
        busy_nxt   = 1'b1;
        err_nxt    = q_item.range_error;
        second_nxt = 1'b0;
        rem_nxt    = q_item.value;
      end
    end else if (!res_full) begin
      res_push = 1'b1;
      if (err_r) begin
        res.symbol_char = NO_CHAR;
        res.last        = 1'b1;
        res.range_error = 1'b1;
        busy_nxt        = 1'b0;
      end else if (second_r) begin
        res.symbol_char = second_char_r;
        res.last        = (rem_r == '0);
        second_nxt      = 1'b0;
        busy_nxt        = (rem_r != '0);
      end else begin
        res.symbol_char = step_first(sel);
        rem_nxt         = rem_sub;
        if (sel_second != NO_CHAR) begin
          res.last        = 1'b0;
          second_nxt      = 1'b1;
          second_char_nxt = sel_second;
        end else begin
          res.last = (rem_sub == '0);
          busy_nxt = (rem_sub != '0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      second_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      second_r <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r         <= err_nxt;
    second_char_r <= second_char_nxt;
    rem_r         <= rem_nxt;
  end

  // Output queue decouples the walk from a stalled receiver.
  irn_fifo #(
    .W     ($bits(irn_result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (head),
    .empty     (out_empty)
  );

  assign out_symbol_char = head.symbol_char;
  assign out_last        = head.last;
  assign out_range_error = head.range_error;

endmodule

// File: rtl/integer_to_roman_numeral.sv
// Top level of the integer to Roman numeral converter.
//
// Input channel: a 12-bit value is taken on a clock edge with in_push high and in_full low.
// Result channel: while out_empty is low, the ports show the oldest letter (ASCII), its last
// flag and its range_error flag; the beat is taken on an edge with out_pop high.
// A value from 1 to 3999 gives its subtractive numeral, most significant letter first, with
// last set on the final letter. Zero or a value above 3999 gives one beat with a zero letter,
// last and range_error set.
// A value passes the front queue and the walk registers before its first letter is queued.
// The back end loads a value and emits all its letters (at most fifteen, for 3888) before it
// takes the next; the table walk emits one letter per cycle while the output queue has room.
// The front queue holds QUEUE_DEPTH values, so new values are taken while one is converted.
// When the receiver stalls, the output queue fills, the walk holds, and then the front
// queue fills and in_full rises. Nothing is dropped.
// Reset (rst_n low, synchronous) empties both queues and abandons any conversion in flight.
module integer_to_roman_numeral #(
  parameter int QUEUE_DEPTH = irn_pkg::QUEUE_DEPTH,
  parameter int OUT_DEPTH   = irn_pkg::OUT_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [irn_pkg::VALUE_W-1:0] in_value,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [irn_pkg::CHAR_W-1:0]  out_symbol_char,
  output logic                        out_last,
  output logic                        out_range_error
);

  import irn_pkg::*;

  irn_item_t q_item;
  logic      q_empty;
  logic      q_pop;

  irn_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_value (in_value),
    .in_full  (in_full),
    .q_pop    (q_pop),
    .q_item   (q_item),
    .q_empty  (q_empty)
  );

  irn_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_item          (q_item),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_symbol_char (out_symbol_char),
    .out_last        (out_last),
    .out_range_error (out_range_error)
  );

endmodule
